### rtl/sgd_pkg.sv
// Shared types, constants and helpers for the Sobel gradient direction block.
`timescale 1ns / 1ps
`default_nettype none

package sgd_pkg;

    // Field and datapath widths.
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 12;
    localparam int GRAD_W      = 11;
    localparam int ABS_W       = 10;
    localparam int SUM_W       = 11;
    localparam int SQ_W        = 20;
    localparam int S2_W        = 22;
    localparam int MAG2_W      = 21;
    localparam int MAG_W       = 8;
    localparam int ROOT_IDX_W  = 3;

    // APB register map.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Defaults.
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Quantized direction codes.
    typedef enum logic [1:0] {
        DIR_0   = 2'd0,
        DIR_45  = 2'd1,
        DIR_90  = 2'd2,
        DIR_135 = 2'd3
    } t_dir;

    // One queued request: the Sobel gradients of an interior centre.
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     last;
    } t_grad;

    // Front to queue.
    typedef struct packed {
        logic  push;
        t_grad item;
    } t_push;

    // Queue status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef enum logic {
        F_IDLE = 1'b0,
        F_WORK = 1'b1
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE = 3'd0,
        B_MUL  = 3'd1,
        B_DIR  = 3'd2,
        B_ROOT = 3'd3,
        B_DONE = 3'd4
    } t_back_state;

    // Effective frame dimension: zero acts as one, large values saturate.
    function automatic logic [31:0] eff_dim(input logic [CFG_W-1:0] v,
                                            input logic [31:0] maxv);
        logic [31:0] ext;
        ext = {{(32-CFG_W){1'b0}}, v};
        if (v == '0) begin
            return 32'd1;
        end
        if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

endpackage

`default_nettype wire

### rtl/sgd_front.sv
// Front part: pixel intake, line buffers, 3x3 window and gradient calculation.
`timescale 1ns / 1ps
`default_nettype none

module sgd_front
    import sgd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic [PIX_W-1:0]                   i_pixel,
    output logic                                    o_stall,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     i_frame_w,
    input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]    i_frame_h,
    input  wire logic                               i_restart,
    input  wire t_qstat                             i_qstat,
    output t_push                                   o_push
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WDW = $clog2(MAX_WIDTH+1);
    localparam int HDW = $clog2(MAX_HEIGHT+1);

    t_front_state r_state, n_state;

    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [PIX_W-1:0] r_pix;
    logic [PIX_W-1:0] r_top;
    logic [PIX_W-1:0] r_mid;
    logic [PIX_W-1:0] r_win [6];

    logic [PIX_W-1:0] r_line_one [MAX_WIDTH];
    logic [PIX_W-1:0] r_line_two [MAX_WIDTH];

    logic accept;
    logic col_end;
    logic row_end;
    logic emit;
    logic [ABS_W-1:0] right_sum, left_sum, top_sum, bot_sum;

    assign accept = i_valid && !o_stall;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake.
    always_comb begin
        n_state = r_state;
        o_stall = 1'b1;
        case (r_state)
            F_IDLE: begin
                o_stall = i_qstat.full;
                if (i_valid && !i_qstat.full) begin
                    n_state = F_WORK;
                end
            end
            F_WORK: begin
                n_state = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // Line buffers: read on accept, write back in the work cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top <= r_line_two[r_col];
            r_mid <= r_line_one[r_col];
            r_pix <= i_pixel;
        end
        if (r_state == F_WORK) begin
            r_line_two[r_col] <= r_mid;
            r_line_one[r_col] <= r_pix;
        end
    end

    // Position in the frame.
    assign col_end = ({{(WDW-CW){1'b0}}, r_col} == i_frame_w - WDW'(1));
    assign row_end = ({{(HDW-RW){1'b0}}, r_row} == i_frame_h - HDW'(1));
    assign emit    = (r_row >= RW'(2)) && (r_col >= CW'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (r_state == F_WORK) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Window of the two previous columns, each top, middle, bottom.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_state == F_WORK) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_top;
            r_win[4] <= r_mid;
            r_win[5] <= r_pix;
        end
    end

    // Sobel sums over the window.
    assign right_sum = {2'b00, r_top} + {1'b0, r_mid, 1'b0} + {2'b00, r_pix};
    assign left_sum  = {2'b00, r_win[0]} + {1'b0, r_win[1], 1'b0} + {2'b00, r_win[2]};
    assign top_sum   = {2'b00, r_win[0]} + {1'b0, r_win[3], 1'b0} + {2'b00, r_top};
    assign bot_sum   = {2'b00, r_win[2]} + {1'b0, r_win[5], 1'b0} + {2'b00, r_pix};

    always_comb begin
        o_push.push      = (r_state == F_WORK) && emit;
        o_push.item.gx   = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        o_push.item.gy   = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
        o_push.item.last = row_end && col_end;
    end

endmodule

`default_nettype wire

### rtl/sgd_queue.sv
// Short request queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module sgd_queue
    import sgd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    input  wire logic   i_pop,
    output t_grad       o_item,
    output t_qstat      o_qstat
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_grad         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push.push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;

    assign o_qstat.full  = (r_count == NW'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_item        = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/sgd_back.sv
// Back part: magnitude by iterative square root and quantized direction.
`timescale 1ns / 1ps
`default_nettype none

module sgd_back
    import sgd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_qstat             i_qstat,
    input  wire t_grad              i_item,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [MAG_W-1:0]        o_magnitude,
    output logic [1:0]              o_direction,
    output logic                    o_last
);

    t_back_state r_state, n_state;

    logic [ABS_W-1:0]      r_ax, r_ay;
    logic                  r_same, r_zero, r_last, r_ay_gt;
    logic [SQ_W-1:0]       r_sqx, r_sqy, r_d2;
    logic [S2_W-1:0]       r_s2;
    logic [MAG2_W-1:0]     r_sum;
    t_dir                  r_dir;
    logic [MAG_W-1:0]      r_root;
    logic [ROOT_IDX_W-1:0] r_idx;

    logic                  r_out_valid;
    logic [MAG_W-1:0]      r_out_mag;
    t_dir                  r_out_dir;
    logic                  r_out_last;

    logic [ABS_W-1:0]      ax_in, ay_in;
    logic [SUM_W-1:0]      s_ax_ay;
    logic [ABS_W-1:0]      d_ay_ax;
    logic [MAG_W-1:0]      trial;
    logic [2*MAG_W-1:0]    trial_sq;
    logic                  out_free;
    logic                  load_out;

    assign out_free = !r_out_valid || !i_stall;
    assign load_out = (r_state == B_DONE) && out_free;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_state = B_DIR;
            end
            B_DIR: begin
                n_state = B_ROOT;
            end
            B_ROOT: begin
                if (r_idx == '0) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign ax_in    = i_item.gx[GRAD_W-1] ? ABS_W'(-i_item.gx) : ABS_W'(i_item.gx);
    assign ay_in    = i_item.gy[GRAD_W-1] ? ABS_W'(-i_item.gy) : ABS_W'(i_item.gy);
    assign s_ax_ay  = {1'b0, r_ax} + {1'b0, r_ay};
    assign d_ay_ax  = r_ay - r_ax;
    assign trial    = r_root | (MAG_W'(1) << r_idx);
    assign trial_sq = {{MAG_W{1'b0}}, trial} * {{MAG_W{1'b0}}, trial};

    // Datapath steps.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    r_ax   <= ax_in;
                    r_ay   <= ay_in;
                    r_zero <= (i_item.gx == '0) && (i_item.gy == '0);
                    r_same <= ($signed(i_item.gx) > 0) == ($signed(i_item.gy) > 0);
                    r_last <= i_item.last;
                end
            end
            B_MUL: begin
                // Squares for the magnitude and the tangent comparisons.
                r_sqx   <= {{ABS_W{1'b0}}, r_ax} * {{ABS_W{1'b0}}, r_ax};
                r_sqy   <= {{ABS_W{1'b0}}, r_ay} * {{ABS_W{1'b0}}, r_ay};
                r_s2    <= {{SUM_W{1'b0}}, s_ax_ay} * {{SUM_W{1'b0}}, s_ax_ay};
                r_d2    <= {{ABS_W{1'b0}}, d_ay_ax} * {{ABS_W{1'b0}}, d_ay_ax};
                r_ay_gt <= r_ay > r_ax;
            end
            B_DIR: begin
                r_sum  <= {1'b0, r_sqx} + {1'b0, r_sqy};
                r_root <= '0;
                r_idx  <= ROOT_IDX_W'(MAG_W - 1);
                if (r_zero) begin
                    r_dir <= DIR_0;
                end else if (r_s2 < {1'b0, r_sqx, 1'b0}) begin
                    r_dir <= DIR_0;
                end else if (r_ay_gt && ({2'b00, r_d2} > {1'b0, r_sqx, 1'b0})) begin
                    r_dir <= DIR_90;
                end else begin
                    r_dir <= r_same ? DIR_45 : DIR_135;
                end
            end
            B_ROOT: begin
                // One result bit per cycle, most significant first.
                if ({{(MAG2_W-2*MAG_W){1'b0}}, trial_sq} <= r_sum) begin
                    r_root <= trial;
                end
                r_idx <= r_idx - ROOT_IDX_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_mag  <= (r_sum[MAG2_W-1:2*MAG_W] != '0) ? {MAG_W{1'b1}} : r_root;
            r_out_dir  <= r_dir;
            r_out_last <= r_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_magnitude = r_out_mag;
    assign o_direction = r_out_dir;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

### rtl/sobel_gradient_direction_top.sv
// Top level of the Sobel gradient magnitude and direction block.
// An interior pixel's result passes the front, the queue, the back's states and its output register.
// The front reads the line buffers on accept and writes back before it takes a new pixel.
// The back works on one interior result at a time, through a bit-serial square root.
// Reset is synchronous, active low; line buffers are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module sobel_gradient_direction_top
    import sgd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [PIX_W-1:0]   i_pixel,
    output logic                    o_stall,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [MAG_W-1:0]        o_magnitude,
    output logic [1:0]              o_direction,
    output logic                    o_last,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [APB_AW-1:0]  paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    localparam int WDW = $clog2(MAX_WIDTH+1);
    localparam int HDW = $clog2(MAX_HEIGHT+1);

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             cfg_write;
    logic [WDW-1:0]   frame_w;
    logic [HDW-1:0]   frame_h;

    t_push  push;
    t_qstat qstat;
    t_grad  q_item;
    logic   pop;

    // Register port: the address bit above the word offset picks the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (cfg_write) begin
            if (paddr[2] == REG_FRAME_WIDTH) begin
                r_frame_width <= pwdata[CFG_W-1:0];
            end else begin
                r_frame_height <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_FRAME_HEIGHT)
                  ? {{(APB_DW-CFG_W){1'b0}}, r_frame_height}
                  : {{(APB_DW-CFG_W){1'b0}}, r_frame_width};

    // Effective frame dimensions.
    assign frame_w = WDW'(eff_dim(r_frame_width, 32'(MAX_WIDTH)));
    assign frame_h = HDW'(eff_dim(r_frame_height, 32'(MAX_HEIGHT)));

    sgd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_pixel   (i_pixel),
        .o_stall   (o_stall),
        .i_frame_w (frame_w),
        .i_frame_h (frame_h),
        .i_restart (cfg_write),
        .i_qstat   (qstat),
        .o_push    (push)
    );

    sgd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_qstat (qstat)
    );

    sgd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (qstat),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_magnitude (o_magnitude),
        .o_direction (o_direction),
        .o_last      (o_last)
    );

    // The front never pushes into a full queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push |-> !qstat.full)
        else $error("gradient request pushed into a full queue");

    // The back never pops an empty queue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("gradient request popped from an empty queue");

    // A frame width write lands in its register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_write && (paddr[2] == REG_FRAME_WIDTH)) |=>
            (r_frame_width == $past(pwdata[CFG_W-1:0])))
        else $error("frame width write lost");

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the Sobel gradient block: a directed frame, then random frames.
`timescale 1ns / 1ps

module tb;
    import sgd_pkg::*;

    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PIXELS  = 2000;
    localparam logic [APB_AW-1:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        t_dir             direction;
        logic             last;
    } grad_out_t;

    // One image row of the directed frame and the result its right pixel should give.
    typedef struct packed {
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] right;
        bit               typed;
        grad_out_t        want;
    } stim_row_t;

    typedef enum int {HOLD_NONE, HOLD_LIGHT, HOLD_HEAVY, HOLD_PERIODIC} hold_mode_t;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [PIX_W-1:0]   i_pixel = '0;
    logic               i_stall = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [APB_AW-1:0]  paddr   = '0;
    logic [APB_DW-1:0]  pwdata  = '0;
    logic               o_stall;
    logic               o_valid;
    logic [MAG_W-1:0]   o_magnitude;
    logic [1:0]         o_direction;
    logic               o_last;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    sobel_gradient_direction_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_magnitude (o_magnitude),
        .o_direction (o_direction),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Directed frame, three pixels wide and nine rows high: one window per row from row 2.
    // Typed rows: a saturated vertical gradient, a lone centre pixel, an unsaturated magnitude
    // of 254 and a small 135 degree step.
    stim_row_t window_rows [9] = '{
        '{8'd0,   8'd0,   8'd0,   1'b0, '{8'd0,   DIR_0,   1'b0}},
        '{8'd0,   8'd0,   8'd0,   1'b0, '{8'd0,   DIR_0,   1'b0}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd255, DIR_90,  1'b0}},
        '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   DIR_0,   1'b0}},
        '{8'd0,   8'd0,   8'd127, 1'b0, '{8'd0,   DIR_0,   1'b0}},
        '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd254, DIR_0,   1'b0}},
        '{8'd0,   8'd0,   8'd1,   1'b0, '{8'd0,   DIR_0,   1'b0}},
        '{8'd1,   8'd0,   8'd0,   1'b1, '{8'd1,   DIR_135, 1'b0}},
        '{8'd255, 8'd255, 8'd255, 1'b0, '{8'd0,   DIR_0,   1'b0}}
    };

    // Predictor state: two previous rows, the two previous columns, and the frame position.
    bit [PIX_W-1:0]   prev_row      [DEF_MAX_WIDTH];
    bit [PIX_W-1:0]   prev_prev_row [DEF_MAX_WIDTH];
    bit [PIX_W-1:0]   col_window    [6];
    int               col_pos = 0;
    int               row_pos = 0;
    logic [CFG_W-1:0] frame_w = RST_FRAME_WIDTH;
    logic [CFG_W-1:0] frame_h = RST_FRAME_HEIGHT;
    grad_out_t        expected_grads [$];

    int unsigned mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          burst_max = 8;
    int          gap_max = 4;
    int          random_sent = 0;
    hold_mode_t  hold_mode = HOLD_NONE;
    logic [2:0]  hold_tick = '0;

    always #5 i_clk = ~i_clk;

    // Effective frame dimension: zero acts as one, anything above the maximum saturates.
    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int limit);
        if (v == '0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    // Floor of the square root, saturated once the root no longer fits in eight bits.
    function automatic logic [MAG_W-1:0] grad_length(input int sq);
        int root;
        if (sq >= 65536) return 8'd255;
        root = 0;
        while ((root + 1) * (root + 1) <= sq) root++;
        return root[MAG_W-1:0];
    endfunction

    // Exact sector test against tan(22.5) and tan(67.5) without any division.
    function automatic t_dir grad_angle(input int gx, input int gy);
        int ax, ay;
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        if (ax == 0 && ay == 0) return DIR_0;
        if ((ax + ay) * (ax + ay) < 2 * ax * ax) return DIR_0;
        if (ay > ax && (ay - ax) * (ay - ax) > 2 * ax * ax) return DIR_90;
        return ((gx > 0) == (gy > 0)) ? DIR_45 : DIR_135;
    endfunction

    // Advance the frame by one accepted pixel and queue the result it completes, if any.
    task automatic predict_pixel(input logic [PIX_W-1:0] pix, input bit use_typed,
                                 input grad_out_t typed);
        int w, h, c, r, gx, gy;
        int lt, lm, lb, mt, mb, rt, rm, rb;
        grad_out_t res;
        w = clamp_dim(frame_w, DEF_MAX_WIDTH);
        h = clamp_dim(frame_h, DEF_MAX_HEIGHT);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        rt = prev_prev_row[c];
        rm = prev_row[c];
        rb = pix;
        if (r >= 2 && c >= 2) begin
            lt = col_window[0];
            lm = col_window[1];
            lb = col_window[2];
            mt = col_window[3];
            mb = col_window[5];
            gx = (rt + 2 * rm + rb) - (lt + 2 * lm + lb);
            gy = (lt + 2 * mt + rt) - (lb + 2 * mb + rb);
            res.magnitude = grad_length(gx * gx + gy * gy);
            res.direction = grad_angle(gx, gy);
            res.last = (r == h - 1 && c == w - 1);
            expected_grads.push_back(use_typed ? typed : res);
        end
        prev_prev_row[c] = rm[PIX_W-1:0];
        prev_row[c] = pix;
        col_window[0] = col_window[3];
        col_window[1] = col_window[4];
        col_window[2] = col_window[5];
        col_window[3] = rt[PIX_W-1:0];
        col_window[4] = rm[PIX_W-1:0];
        col_window[5] = pix;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // One request on the pixel channel, preceded by a random gap at the start of a burst.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit use_typed,
                              input grad_out_t typed);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        predict_pixel(pix, use_typed, typed);
        @(negedge i_clk);
    endtask

    // One APB transfer; a write also updates the predictor and restarts the frame position.
    task automatic apb_xfer(input bit wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr) begin
            if (addr == ADDR_FRAME_WIDTH) begin
                frame_w = wdata[CFG_W-1:0];
            end else begin
                frame_h = wdata[CFG_W-1:0];
            end
            col_pos = 0;
            row_pos = 0;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] want);
        logic [APB_DW-1:0] got;
        apb_xfer(1'b0, addr, '0, got);
        if (got[CFG_W-1:0] !== want) begin
            $display("%0t: register 0x%0h expected %0d actual %0d",
                     $time, addr, want, got[CFG_W-1:0]);
            mismatches++;
        end
    endtask

    // Write a dimension with random upper bits, which the register must drop, and read it back.
    task automatic set_reg(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] wdata, unused;
        wdata = $urandom();
        wdata[CFG_W-1:0] = value;
        apb_xfer(1'b1, addr, wdata, unused);
        check_reg(addr, value);
    endtask

    // Hold off new pixels until every queued result is out and the block has gone quiet.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_grads.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reconfigure the frame, pick new idling behavior and stream random pixels.
    task automatic run_frames(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                              input int count);
        logic [PIX_W-1:0] pix;
        drain_results();
        if ($urandom_range(0, 1) == 0) begin
            set_reg(ADDR_FRAME_WIDTH, w_val);
            set_reg(ADDR_FRAME_HEIGHT, h_val);
        end else begin
            set_reg(ADDR_FRAME_HEIGHT, h_val);
            set_reg(ADDR_FRAME_WIDTH, w_val);
        end
        hold_mode = hold_mode_t'($urandom_range(0, 3));
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        burst_max = $urandom_range(1, 24);
        burst_left = 0;
        repeat (count) begin
            case ($urandom_range(0, 7))
                0: pix = '0;
                1: pix = '1;
                default: pix = $urandom_range(0, 255);
            endcase
            send_pixel(pix, 1'b0, '0);
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver stall pattern, changed per phase.
    always @(negedge i_clk) begin
        hold_tick <= hold_tick + 3'd1;
        case (hold_mode)
            HOLD_NONE:  i_stall <= 1'b0;
            HOLD_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            HOLD_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:    i_stall <= (hold_tick >= 3'd5);
        endcase
    end

    // Every accepted result must match the oldest expectation.
    always @(posedge i_clk) begin : result_check
        grad_out_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_grads.size() == 0) begin
                $display("%0t: result with nothing expected: magnitude %0d direction %0d last %0b",
                         $time, o_magnitude, o_direction, o_last);
                mismatches++;
            end else begin
                want = expected_grads.pop_front();
                compare_field("magnitude", want.magnitude, o_magnitude);
                compare_field("direction", {6'd0, want.direction}, {6'd0, o_direction});
                compare_field("last", {7'd0, want.last}, {7'd0, o_last});
            end
        end
    end

    // Watchdog: ends the run when no request moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int sel, w_val, h_val, count, area;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        check_reg(ADDR_FRAME_WIDTH, RST_FRAME_WIDTH);
        check_reg(ADDR_FRAME_HEIGHT, RST_FRAME_HEIGHT);

        // Directed frame, checked against typed values where obvious.
        hold_mode = HOLD_LIGHT;
        set_reg(ADDR_FRAME_WIDTH, 12'd3);
        set_reg(ADDR_FRAME_HEIGHT, 12'd9);
        foreach (window_rows[k]) begin
            send_pixel(window_rows[k].left, 1'b0, '0);
            send_pixel(window_rows[k].mid, 1'b0, '0);
            send_pixel(window_rows[k].right, window_rows[k].typed, window_rows[k].want);
        end

        // Random small frames, mostly whole frames; some too narrow or too short for results.
        while (random_sent < RANDOM_PIXELS) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                w_val = $urandom_range(0, 2);
                h_val = $urandom_range(1, 6);
            end else if (sel == 1) begin
                w_val = $urandom_range(3, 8);
                h_val = $urandom_range(0, 2);
            end else if (sel == 2) begin
                w_val = $urandom_range(13, 300);
                h_val = 3;
            end else begin
                w_val = $urandom_range(3, 12);
                h_val = $urandom_range(3, 8);
            end
            area = clamp_dim(w_val[CFG_W-1:0], DEF_MAX_WIDTH)
                 * clamp_dim(h_val[CFG_W-1:0], DEF_MAX_HEIGHT);
            if (sel == 2) begin
                count = area;
            end else if ($urandom_range(0, 3) == 0) begin
                count = $urandom_range(1, 2 * area);
            end else begin
                count = area * $urandom_range(1, 3);
            end
            if (count > RANDOM_PIXELS - random_sent) begin
                count = RANDOM_PIXELS - random_sent;
            end
            run_frames(w_val[CFG_W-1:0], h_val[CFG_W-1:0], count);
            random_sent += count;
        end

        // Over-range dimensions: the registers keep the written value and pixels still flow.
        run_frames(12'hFFF, 12'hFFF, 16);

        drain_results();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
